// File: src/sflg_pkg.sv
// shared constants, types and helper functions of the stereo flanger
package sflg_pkg;

    // delay line and sine table geometry (both sizes are powers of two)
    localparam int LINE_WORDS   = 1024;
    localparam int LINE_BITS    = $clog2(LINE_WORDS);
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);

    // sample and delay arithmetic widths
    localparam int SMP_W     = 24;
    localparam int FRAC_BITS = 8;
    localparam int POS_W     = LINE_BITS + FRAC_BITS;
    localparam int DMOD_W    = 18;
    localparam int DSUM_W    = 19;
    localparam int SAT_W     = 48;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // limits of the configuration values
    localparam logic [19:0] STEP_MIN = 20'd894;
    localparam logic [19:0] STEP_MAX = 20'd894785;
    localparam logic signed [15:0] FB_MAX = 16'sd31130;
    localparam logic signed [15:0] FB_MIN = -16'sd31130;
    localparam logic [16:0] MIX_FULL = 17'd65536;

    // longest delay: one sample short of the line, in 1/256 samples
    localparam logic [POS_W-1:0] DELAY_MAX = POS_W'(LINE_WORDS * 256 - 256);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP  = 3'd0,
        REG_MIN_DELAY   = 3'd1,
        REG_SWEEP_DEPTH = 3'd2,
        REG_FEEDBACK    = 3'd3,
        REG_WET_MIX     = 3'd4
    } t_reg_idx;

    // per-word sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEPTH,
        ST_ADDR,
        ST_READ,
        ST_INTERP,
        ST_MULT,
        ST_FIN
    } t_state;

    // gains handed to each channel datapath
    typedef struct packed {
        logic signed [15:0] fb;
        logic [16:0]        wet;
        logic [16:0]        dry;
    } t_coef;

    typedef logic signed [15:0] t_sine_rom [SINE_ENTRIES];

    localparam longint Q30_ONE = 64'sd1 << 30;

    // one sine entry from a ninth-order polynomial on the quarter wave
    function automatic logic signed [15:0] sine_value(input int idx);
        longint turn;
        longint x;
        longint x2;
        longint p;
        longint y;
        longint s;
        int quad;
        turn = (longint'(idx) << 32) / SINE_ENTRIES;
        quad = int'((turn >>> 30) & 64'sd3);
        x = turn & 64'sh3FFFFFFF;
        if ((quad & 1) != 0) begin
            x = Q30_ONE - x;
        end
        x2 = x * x / Q30_ONE;
        p = 64'sd172272;
        p = -64'sd5026996 + p * x2 / Q30_ONE;
        p = 64'sd85569312 + p * x2 / Q30_ONE;
        p = -64'sd693598671 + p * x2 / Q30_ONE;
        p = 64'sd1686629713 + p * x2 / Q30_ONE;
        y = x * p / Q30_ONE;
        s = (y + 64'sd16384) / 64'sd32768;
        if (s > 64'sd32767) begin
            s = 64'sd32767;
        end
        if (s < 64'sd0) begin
            s = 64'sd0;
        end
        if ((quad & 2) != 0) begin
            s = -s;
        end
        return 16'(s);
    endfunction

    // whole sine table, built at elaboration
    function automatic t_sine_rom sine_rom();
        t_sine_rom rom;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            rom[i] = sine_value(i);
        end
        return rom;
    endfunction

    // clamp a wide signed value to the sample range
    function automatic logic signed [SMP_W-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
        if (v > 48'sh7FFFFF) begin
            return 24'sh7FFFFF;
        end else if (v < -48'sh800000) begin
            return -24'sh800000;
        end else begin
            return $signed(v[SMP_W-1:0]);
        end
    endfunction

endpackage

// File: src/sflg_sine.sv
// sine table rom with registered read
module sflg_sine (
    input  logic                              i_clk,
    input  logic [sflg_pkg::SINE_BITS-1:0]    i_idx,
    output logic signed [15:0]                o_sine
);

    localparam sflg_pkg::t_sine_rom SINE_ROM = sflg_pkg::sine_rom();

    logic signed [15:0] r_sine;

    // one read a cycle
    always_ff @(posedge i_clk) begin
        r_sine <= SINE_ROM[i_idx];
    end

    assign o_sine = r_sine;

endmodule

// File: src/sflg_line.sv
// one channel's circular delay line: one write port, two registered read ports
module sflg_line (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [sflg_pkg::LINE_BITS-1:0]    i_waddr,
    input  logic signed [sflg_pkg::SMP_W-1:0] i_wdata,
    input  logic [sflg_pkg::LINE_BITS-1:0]    i_raddr_a,
    input  logic [sflg_pkg::LINE_BITS-1:0]    i_raddr_b,
    output logic signed [sflg_pkg::SMP_W-1:0] o_rdata_a,
    output logic signed [sflg_pkg::SMP_W-1:0] o_rdata_b
);

    logic [sflg_pkg::SMP_W-1:0] r_mem [sflg_pkg::LINE_WORDS];
    logic [sflg_pkg::SMP_W-1:0] r_rd_a;
    logic [sflg_pkg::SMP_W-1:0] r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // the two interpolation taps
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = $signed(r_rd_a);
    assign o_rdata_b = $signed(r_rd_b);

endmodule

// File: src/sflg_chan.sv
// per-channel datapath: interpolation, feedback and dry/wet mix
module sflg_chan (
    input  logic                              i_clk,
    input  logic signed [sflg_pkg::SMP_W-1:0] i_rd_a,
    input  logic signed [sflg_pkg::SMP_W-1:0] i_rd_b,
    input  logic                              i_ok_a,
    input  logic                              i_ok_b,
    input  logic [sflg_pkg::FRAC_BITS-1:0]    i_frac,
    input  logic signed [sflg_pkg::SMP_W-1:0] i_x,
    input  sflg_pkg::t_coef                   i_coef,
    output logic signed [sflg_pkg::SMP_W-1:0] o_wdata,
    output logic signed [sflg_pkg::SMP_W-1:0] o_out
);

    logic signed [23:0] a;
    logic signed [23:0] b;
    logic signed [24:0] diff;
    logic signed [33:0] iprod;
    logic signed [33:0] iprod_b;
    logic signed [33:0] dl_full;
    logic signed [23:0] r_dl;
    logic signed [39:0] r_pfb;
    logic signed [41:0] r_pwet;
    logic signed [41:0] r_pdry;
    logic signed [39:0] fb_b;
    logic signed [39:0] fbq;
    logic signed [42:0] mix;
    logic signed [42:0] mix_b;
    logic signed [42:0] mq;

    // unwritten slots read as silence
    always_comb begin
        a = i_ok_a ? i_rd_a : '0;
        b = i_ok_b ? i_rd_b : '0;
        diff = 25'(b) - 25'(a);
        iprod = 34'(diff) * 34'($signed({1'b0, i_frac}));
        iprod_b = iprod + (iprod[33] ? 34'sd255 : 34'sd0);
        dl_full = 34'(a) + (iprod_b >>> 8);
    end

    // interpolated sample
    always_ff @(posedge i_clk) begin
        r_dl <= dl_full[23:0];
    end

    // feedback, wet and dry products
    always_ff @(posedge i_clk) begin
        r_pfb  <= 40'(r_dl) * 40'($signed(i_coef.fb));
        r_pwet <= 42'(r_dl) * 42'($signed({1'b0, i_coef.wet}));
        r_pdry <= 42'(i_x) * 42'($signed({1'b0, i_coef.dry}));
    end

    // scale toward zero and saturate
    always_comb begin
        fb_b  = r_pfb + (r_pfb[39] ? 40'sd32767 : 40'sd0);
        fbq   = fb_b >>> 15;
        mix   = 43'(r_pwet) + 43'(r_pdry);
        mix_b = mix + (mix[42] ? 43'sd65535 : 43'sd0);
        mq    = mix_b >>> 16;
    end

    assign o_wdata = sflg_pkg::sat_sample(48'(i_x) + 48'(fbq));
    assign o_out   = sflg_pkg::sat_sample(48'(mq));

endmodule

// File: src/stereo_flanger.sv
// stereo flanger top level: config registers, lfo, sequencer and output register
// an accepted word walks ST_DEPTH to ST_FIN; its result is registered on leaving ST_FIN,
// which waits while an output word is pending; the sequencer walks the sine rom, the
//   delay-line read, interpolation, products and write-back of a word before the next one
// reset: synchronous active-low; lines read as zero until written (fill count), no clear pass
// configuration registers reset to their defaults, lfo phase and write slot to zero
module stereo_flanger (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [47:0]                          s_axis_tdata,   // left_in, right_in
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [47:0]                          m_axis_tdata,   // left_out, right_out
    input  logic                                 i_cfg_we,
    input  logic [sflg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sflg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int LB = sflg_pkg::LINE_BITS;
    localparam int PW = sflg_pkg::POS_W;
    localparam logic [LB:0] FILL_FULL = (LB + 1)'(sflg_pkg::LINE_WORDS);

    // configuration registers
    logic [19:0]        r_phase_step;
    logic [17:0]        r_min_delay;
    logic [17:0]        r_sweep_depth;
    logic signed [15:0] r_fb_gain;
    logic [16:0]        r_wet_mix;

    // sequencer and state
    sflg_pkg::t_state r_state;
    sflg_pkg::t_state n_state;
    logic [31:0]      r_phase;
    logic [LB-1:0]    r_wr_idx;
    logic [LB:0]      r_fill;
    logic             w_fin_go;

    // per-word payload
    logic signed [23:0]                 r_xl;
    logic signed [23:0]                 r_xr;
    logic [sflg_pkg::DMOD_W-1:0]        r_dmod;
    logic [LB-1:0]                      r_i0;
    logic [LB-1:0]                      r_i1;
    logic [sflg_pkg::FRAC_BITS-1:0]     r_frac;
    logic                               r_ok_a;
    logic                               r_ok_b;
    logic                               r_out_valid;
    logic [47:0]                        r_out_data;

    // derived values
    logic [19:0]                    step_sat;
    sflg_pkg::t_coef                coef;
    logic signed [15:0]             w_sine;
    logic [16:0]                    sine_off;
    logic [34:0]                    dprod;
    logic [sflg_pkg::DSUM_W-1:0]    dsum;
    logic [PW-1:0]                  dly;
    logic [PW-1:0]                  pos;
    logic [LB-1:0]                  i0;

    logic signed [23:0] w_rd_la;
    logic signed [23:0] w_rd_lb;
    logic signed [23:0] w_rd_ra;
    logic signed [23:0] w_rd_rb;
    logic signed [23:0] w_wd_l;
    logic signed [23:0] w_wd_r;
    logic signed [23:0] w_out_l;
    logic signed [23:0] w_out_r;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= 20'd8948;
            r_min_delay   <= 18'd256;
            r_sweep_depth <= 18'd0;
            r_fb_gain     <= 16'sd0;
            r_wet_mix     <= 17'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sflg_pkg::REG_PHASE_STEP:  r_phase_step  <= i_cfg_data[19:0];
                sflg_pkg::REG_MIN_DELAY:   r_min_delay   <= i_cfg_data[17:0];
                sflg_pkg::REG_SWEEP_DEPTH: r_sweep_depth <= i_cfg_data[17:0];
                sflg_pkg::REG_FEEDBACK:    r_fb_gain     <= $signed(i_cfg_data[15:0]);
                sflg_pkg::REG_WET_MIX:     r_wet_mix     <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // clamp the configuration to its legal ranges
    always_comb begin
        if (r_phase_step < sflg_pkg::STEP_MIN) begin
            step_sat = sflg_pkg::STEP_MIN;
        end else if (r_phase_step > sflg_pkg::STEP_MAX) begin
            step_sat = sflg_pkg::STEP_MAX;
        end else begin
            step_sat = r_phase_step;
        end
        if (r_fb_gain > sflg_pkg::FB_MAX) begin
            coef.fb = sflg_pkg::FB_MAX;
        end else if (r_fb_gain < sflg_pkg::FB_MIN) begin
            coef.fb = sflg_pkg::FB_MIN;
        end else begin
            coef.fb = r_fb_gain;
        end
        coef.wet = (r_wet_mix > sflg_pkg::MIX_FULL) ? sflg_pkg::MIX_FULL : r_wet_mix;
        coef.dry = sflg_pkg::MIX_FULL - coef.wet;
    end

    // lfo table lookup at the current phase
    sflg_sine u_sine (
        .i_clk  (i_clk),
        .i_idx  (r_phase[31 -: sflg_pkg::SINE_BITS]),
        .o_sine (w_sine)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sflg_pkg::ST_IDLE:   if (s_axis_tvalid) n_state = sflg_pkg::ST_DEPTH;
            sflg_pkg::ST_DEPTH:  n_state = sflg_pkg::ST_ADDR;
            sflg_pkg::ST_ADDR:   n_state = sflg_pkg::ST_READ;
            sflg_pkg::ST_READ:   n_state = sflg_pkg::ST_INTERP;
            sflg_pkg::ST_INTERP: n_state = sflg_pkg::ST_MULT;
            sflg_pkg::ST_MULT:   n_state = sflg_pkg::ST_FIN;
            sflg_pkg::ST_FIN:    if (w_fin_go) n_state = sflg_pkg::ST_IDLE;
            default:             n_state = sflg_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = (r_state == sflg_pkg::ST_IDLE);
        w_fin_go = (r_state == sflg_pkg::ST_FIN) && (!r_out_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sflg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture the input word
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_xl <= $signed(s_axis_tdata[23:0]);
            r_xr <= $signed(s_axis_tdata[47:24]);
        end
    end

    // sweep share of the delay
    always_comb begin
        sine_off = 17'(w_sine) + 17'd32768;
        dprod = 35'(sine_off) * 35'(r_sweep_depth);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sflg_pkg::ST_DEPTH) begin
            r_dmod <= dprod[33:16];
        end
    end

    // read position behind the write slot
    always_comb begin
        dsum = sflg_pkg::DSUM_W'(r_min_delay) + sflg_pkg::DSUM_W'(r_dmod);
        if (32'(dsum) > 32'(sflg_pkg::DELAY_MAX)) begin
            dly = sflg_pkg::DELAY_MAX;
        end else begin
            dly = PW'(dsum);
        end
        pos = {r_wr_idx, {sflg_pkg::FRAC_BITS{1'b0}}} - dly;
        i0 = pos[PW-1:sflg_pkg::FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sflg_pkg::ST_ADDR) begin
            r_i0   <= i0;
            r_i1   <= i0 + 1'b1;
            r_frac <= pos[sflg_pkg::FRAC_BITS-1:0];
            r_ok_a <= ({1'b0, i0} < r_fill);
            r_ok_b <= ({1'b0, LB'(i0 + 1'b1)} < r_fill);
        end
    end

    // delay lines
    sflg_line u_line_l (
        .i_clk     (i_clk),
        .i_we      (w_fin_go),
        .i_waddr   (r_wr_idx),
        .i_wdata   (w_wd_l),
        .i_raddr_a (r_i0),
        .i_raddr_b (r_i1),
        .o_rdata_a (w_rd_la),
        .o_rdata_b (w_rd_lb)
    );

    sflg_line u_line_r (
        .i_clk     (i_clk),
        .i_we      (w_fin_go),
        .i_waddr   (r_wr_idx),
        .i_wdata   (w_wd_r),
        .i_raddr_a (r_i0),
        .i_raddr_b (r_i1),
        .o_rdata_a (w_rd_ra),
        .o_rdata_b (w_rd_rb)
    );

    // channel datapaths
    sflg_chan u_chan_l (
        .i_clk   (i_clk),
        .i_rd_a  (w_rd_la),
        .i_rd_b  (w_rd_lb),
        .i_ok_a  (r_ok_a),
        .i_ok_b  (r_ok_b),
        .i_frac  (r_frac),
        .i_x     (r_xl),
        .i_coef  (coef),
        .o_wdata (w_wd_l),
        .o_out   (w_out_l)
    );

    sflg_chan u_chan_r (
        .i_clk   (i_clk),
        .i_rd_a  (w_rd_ra),
        .i_rd_b  (w_rd_rb),
        .i_ok_a  (r_ok_a),
        .i_ok_b  (r_ok_b),
        .i_frac  (r_frac),
        .i_x     (r_xr),
        .i_coef  (coef),
        .o_wdata (w_wd_r),
        .o_out   (w_out_r)
    );

    // write slot, fill count and lfo advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_fill   <= '0;
            r_phase  <= '0;
        end else if (w_fin_go) begin
            r_wr_idx <= r_wr_idx + 1'b1;
            r_phase  <= r_phase + 32'(step_sat);
            if (r_fill != FILL_FULL) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_out_data <= {w_out_r, w_out_l};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == sflg_pkg::ST_DEPTH))
        else $error("accepted word did not start the sequence");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count past line length");

    a_slot_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_go |=> (r_wr_idx == LB'($past(r_wr_idx) + 1'b1)))
        else $error("write slot did not advance after write-back");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_fin_go))
        else $error("output word appeared without a write-back");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_fin_go)
        else $error("pending output word overwritten");
`endif

endmodule

// File: test/stereo_flanger_chk.sv
// scoreboard for the stereo flanger: mirrors lfo, delay lines and gains, checks every output word
`timescale 1ns / 100ps

module stereo_flanger_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [47:0]                       i_in_data,    // left_in, right_in
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [47:0]                       i_out_data,   // left_out, right_out
    input  logic                              i_cfg_we,
    input  logic [sflg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sflg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_pending,
    output int                                o_errors
);
    import sflg_pkg::*;

    localparam int     LINE       = LINE_WORDS;
    localparam longint SPAN       = longint'(LINE) * 256;
    localparam longint DELAY_TOP  = SPAN - 256;
    localparam longint RATE_LO    = 894;
    localparam longint RATE_HI    = 894785;
    localparam longint GAIN_LIM   = 31130;
    localparam longint WET_FULL   = 65536;
    localparam longint UNIT_Q30   = 64'sd1 << 30;
    localparam int     WAVE_SHIFT = 32 - $clog2(SINE_ENTRIES);

    // mirrored state of the block
    int          left_hist [LINE];
    int          right_hist[LINE];
    int          lfo_wave  [SINE_ENTRIES];
    int unsigned wr_slot;
    bit [31:0]   lfo_acc;

    // mirrored configuration
    bit [19:0]        rate_r;
    bit [17:0]        base_r;
    bit [17:0]        sweep_r;
    bit signed [15:0] gain_r;
    bit [16:0]        wet_r;

    logic [47:0] mixed_q[$];
    int          error_cnt;

    // quarter-wave polynomial, Q30 coefficients, rounded to Q1.15
    function automatic int wave_point(input int k);
        longint ang;
        longint u;
        longint u2;
        longint acc;
        longint y;
        longint s;
        int     quarter;
        ang = (longint'(k) << 32) / SINE_ENTRIES;
        quarter = int'((ang >> 30) & 3);
        u = ang & 64'sh3FFFFFFF;
        if (quarter[0]) begin
            u = UNIT_Q30 - u;
        end
        u2 = u * u / UNIT_Q30;
        acc = 64'sd172272;
        acc = -64'sd5026996 + acc * u2 / UNIT_Q30;
        acc = 64'sd85569312 + acc * u2 / UNIT_Q30;
        acc = -64'sd693598671 + acc * u2 / UNIT_Q30;
        acc = 64'sd1686629713 + acc * u2 / UNIT_Q30;
        y = u * acc / UNIT_Q30;
        s = (y + 64'sd16384) / 64'sd32768;
        if (s > 32767) begin
            s = 32767;
        end
        if (s < 0) begin
            s = 0;
        end
        return quarter[1] ? -int'(s) : int'(s);
    endfunction

    function automatic longint clip24(input longint v);
        if (v > 64'sd8388607) begin
            return 64'sd8388607;
        end
        if (v < -64'sd8388608) begin
            return -64'sd8388608;
        end
        return v;
    endfunction

    // one stereo word through the flanger, advancing the mirrored state
    task automatic mix_next_pair(input logic [47:0] pair, output logic [47:0] mixed);
        longint dry_l;
        longint dry_r;
        longint rate;
        longint gain;
        longint wet;
        longint delay;
        longint pos;
        longint frac;
        longint tap_l;
        longint tap_r;
        longint out_l;
        longint out_r;
        int     i0;
        int     i1;
        dry_l = longint'($signed(pair[23:0]));
        dry_r = longint'($signed(pair[47:24]));

        rate = longint'(rate_r);
        if (rate < RATE_LO) rate = RATE_LO;
        if (rate > RATE_HI) rate = RATE_HI;
        gain = longint'(gain_r);
        if (gain > GAIN_LIM) gain = GAIN_LIM;
        if (gain < -GAIN_LIM) gain = -GAIN_LIM;
        wet = (longint'(wet_r) > WET_FULL) ? WET_FULL : longint'(wet_r);

        // delay from the sine entry picked by the phase before it advances
        delay = longint'(base_r) +
                ((longint'(lfo_wave[lfo_acc >> WAVE_SHIFT] + 32768) * longint'(sweep_r)) >> 16);
        if (delay > DELAY_TOP) delay = DELAY_TOP;

        // read position behind the write slot, with wrap
        pos  = (longint'(wr_slot) * 256 + SPAN - delay) % SPAN;
        i0   = int'(pos >> 8);
        i1   = (i0 + 1) % LINE;
        frac = pos & 255;

        // linear interpolation, truncated toward zero
        tap_l = longint'(left_hist[i0]) +
                (longint'(left_hist[i1]) - longint'(left_hist[i0])) * frac / 256;
        tap_r = longint'(right_hist[i0]) +
                (longint'(right_hist[i1]) - longint'(right_hist[i0])) * frac / 256;

        // write-back after the read, so a sub-sample delay sees the old slot
        left_hist[wr_slot]  = int'(clip24(dry_l + tap_l * gain / 32768));
        right_hist[wr_slot] = int'(clip24(dry_r + tap_r * gain / 32768));

        out_l = clip24((dry_l * (WET_FULL - wet) + tap_l * wet) / WET_FULL);
        out_r = clip24((dry_r * (WET_FULL - wet) + tap_r * wet) / WET_FULL);
        mixed = {out_r[23:0], out_l[23:0]};

        wr_slot = (wr_slot + 1) % LINE;
        lfo_acc = lfo_acc + 32'(rate);
    endtask

    function automatic void compare_sample(input string tag, input logic [23:0] want,
                                           input logic [23:0] got);
        if (got !== want) begin
            error_cnt++;
            $display("%0t: %s expected %0d got %0d", $time, tag, $signed(want),
                     $signed(got));
        end
    endfunction

    // sine table
    initial begin
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            lfo_wave[k] = wave_point(k);
        end
    end

    // follow config writes, predict accepted words, compare returned words
    always @(posedge i_clk) begin
        logic [47:0] want;
        if (!i_rst_n) begin
            for (int k = 0; k < LINE; k++) begin
                left_hist[k]  = 0;
                right_hist[k] = 0;
            end
            wr_slot   = 0;
            lfo_acc   = '0;
            rate_r    = 20'd8948;
            base_r    = 18'd256;
            sweep_r   = 18'd0;
            gain_r    = 16'sd0;
            wet_r     = 17'd32768;
            error_cnt = 0;
            mixed_q.delete();
            o_pending <= 0;
            o_errors  <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PHASE_STEP:  rate_r  = i_cfg_data[19:0];
                    REG_MIN_DELAY:   base_r  = i_cfg_data[17:0];
                    REG_SWEEP_DEPTH: sweep_r = i_cfg_data[17:0];
                    REG_FEEDBACK:    gain_r  = $signed(i_cfg_data[15:0]);
                    REG_WET_MIX:     wet_r   = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                mix_next_pair(i_in_data, want);
                mixed_q.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (mixed_q.size() == 0) begin
                    error_cnt++;
                    $display("%0t: output word expected none got %h", $time, i_out_data);
                end else begin
                    want = mixed_q.pop_front();
                    compare_sample("left_out", want[23:0], i_out_data[23:0]);
                    compare_sample("right_out", want[47:24], i_out_data[47:24]);
                end
            end
            o_pending <= mixed_q.size();
            o_errors  <= error_cnt;
        end
    end

endmodule

// File: test/stereo_flanger_tb.sv
// testbench top for the stereo flanger: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 100ps

module stereo_flanger_tb;
    import sflg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS   = 125;
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 2000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [47:0]           s_axis_tdata  = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire  [47:0]           m_axis_tdata;
    int                    pending;
    int                    errors;
    bit                    steady;

    stereo_flanger dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    stereo_flanger_chk chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // gap length: mostly none or short, now and then long; none in steady phases
    function automatic int idle_span();
        int pick;
        if (steady) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    function automatic logic [23:0] any_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 24'($urandom);
            6, 7:             return 24'($urandom_range(0, 2000) - 1000);
            8:                return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default:          return 24'h7FFFFF - 24'($urandom_range(0, 255));
        endcase
    endfunction

    // one stereo word, held until taken
    task automatic send_pair(input logic [23:0] left, input logic [23:0] right);
        int span;
        span = idle_span();
        if (span > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (span) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // full-scale, zero and bit-pattern words
    task automatic send_corners(input int count);
        for (int k = 0; k < count; k++) begin
            case (k)
                0: send_pair(24'h7FFFFF, 24'h800000);
                1: send_pair(24'h800000, 24'h7FFFFF);
                2: send_pair(24'h000000, 24'h000000);
                3: send_pair(24'hFFFFFF, 24'h000001);
                4: send_pair(24'h555555, 24'hAAAAAA);
                default: send_pair(24'hAAAAAA, 24'h555555);
            endcase
        end
    endtask

    // wait for the last word back plus the block's own latency
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // all five registers, junk in the unused upper data bits
    task automatic load_setting(input int unsigned step, input int unsigned base,
                                input int unsigned sweep, input int gain,
                                input int unsigned wet);
        put_reg(REG_PHASE_STEP, 20'(step));
        put_reg(REG_MIN_DELAY, {2'($urandom), 18'(base)});
        put_reg(REG_SWEEP_DEPTH, {2'($urandom), 18'(sweep)});
        put_reg(REG_FEEDBACK, {4'($urandom), 16'(gain)});
        put_reg(REG_WET_MIX, {3'($urandom), 17'(wet)});
        i_cfg_we <= 1'b0;
    endtask

    // random setting, biased to short delays and fast sweeps, extremes now and then
    task automatic load_random_setting();
        int unsigned step;
        int unsigned base;
        int unsigned sweep;
        int          gain;
        int unsigned wet;
        case ($urandom_range(0, 9))
            0:          step = $urandom_range(0, 893);
            1:          step = $urandom_range(894785, 1048575);
            2, 3, 4, 5: step = $urandom_range(600000, 894785);
            default:    step = $urandom_range(894, 894785);
        endcase
        case ($urandom_range(0, 5))
            0:       base = $urandom_range(0, 255);
            1:       base = $urandom_range(200000, 262143);
            default: base = $urandom_range(0, 64 * 256);
        endcase
        case ($urandom_range(0, 5))
            0:       sweep = 0;
            1:       sweep = $urandom_range(200000, 262143);
            default: sweep = $urandom_range(0, 64 * 256);
        endcase
        case ($urandom_range(0, 5))
            0:       gain = int'($urandom_range(0, 65535)) - 32768;
            1:       gain = $urandom_range(0, 1) ? 31130 : -31130;
            default: gain = int'($urandom_range(0, 62260)) - 31130;
        endcase
        case ($urandom_range(0, 5))
            0:       wet = $urandom_range(65536, 131071);
            1:       wet = $urandom_range(0, 1) ? 65536 : 0;
            default: wet = $urandom_range(0, 65536);
        endcase
        load_setting(step, base, sweep, gain, wet);
    endtask

    // receiver back-pressure
    initial begin
        int span;
        @(posedge i_rst_n);
        @(posedge i_clk);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            span = idle_span();
            if (span > 0) begin
                m_axis_tready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        steady = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults
        send_corners(6);
        settle();

        // zero delay, rate below range, gain and mix above range
        load_setting(0, 0, 0, 32767, 131071);
        send_corners(6);
        settle();

        // delay past the line end, rate above range, gain below range, fully dry
        load_setting(20'hFFFFF, 18'h3FFFF, 18'h3FFFF, -32768, 0);
        send_corners(6);
        settle();

        // write to an unused index, then a mid setting with fractional delay
        put_reg(REG_SPARE, 20'($urandom));
        load_setting(894785, 5 * 256 + 128, 4 * 256, 16384, 40000);
        send_corners(4);
        settle();

        // random phases, every third without gaps
        for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
            steady = (ph % 3 == 0);
            load_random_setting();
            repeat (PHASE_WORDS) send_pair(any_sample(), any_sample());
            settle();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
